// ===== hw/rtl/srrt_pkg.sv =====
package srrt_pkg;

   localparam int LEVELS       = 4;
   localparam int MAX_RANGES   = 16;
   localparam int BUFFER_BYTES = 16384;

   localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int RIDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W   = $clog2(MAX_RANGES + 2);
   localparam int BUF_AW  = $clog2(BUFFER_BYTES);
   localparam int POS_W   = BUF_AW + 1;
   localparam int RNG_AW  = 1 + LVL_W + RIDX_W;
   localparam int RNG_DEPTH  = 2 * LEVELS * (1 << RIDX_W);
   localparam int BYTE_AW    = LVL_W + BUF_AW;
   localparam int BYTE_DEPTH = LEVELS * BUFFER_BYTES;

   typedef enum logic [2:0] {
      REQ_SEGMENT = 3'd0,
      REQ_RELEASE = 3'd1,
      REQ_DUP     = 3'd2,
      REQ_READ    = 3'd3,
      REQ_CLEAR   = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      STS_OK         = 3'd0,
      STS_BEYOND     = 3'd1,
      STS_FULL       = 3'd2,
      STS_RELEASE    = 3'd3,
      STS_READ_RANGE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_PROC,
      ST_EMIT2,
      ST_END,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/stream_reassembly_range_tracker_top.sv =====
// Out-of-order stream reassembly buffer with one byte store and one sorted set of
// received ranges per stream level. Segment bytes are taken one per cycle with no
// result, except the final byte of a segment. Release, duplicate query, clear and
// unused request types go from idle to the done state, which registers the result;
// a byte read is registered by the byte memory on acceptance. A final segment byte
// walks the level's range list in the range memory, with a read and a process state
// per stored range, an extra emit state when the new range lands ahead of a stored
// range, then an end state. The range list is rewritten into the other half of a
// ping-pong range memory and committed by flipping the level's bank bit, so a
// full range set leaves the list untouched. No clearing pass is needed after reset.
module stream_reassembly_range_tracker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [1:0]  req_level,
   input  logic [31:0] req_offset,
   input  logic [15:0] req_length,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [14:0] rsp_prefix_len,
   output logic [14:0] rsp_consumed_count,
   output logic [14:0] rsp_available,
   output logic        rsp_is_duplicate,
   output logic [7:0]  rsp_read_byte,
   output logic [4:0]  rsp_range_count_out
);
   import srrt_pkg::*;

   // memories
   logic [7:0]  byte_mem [0:BYTE_DEPTH-1];
   logic [29:0] rng_mem  [0:RNG_DEPTH-1];

   // per-level state
   logic [CNT_W-1:0] cnt_ff    [0:LEVELS-1];
   logic [CNT_W-1:0] cnt_in    [0:LEVELS-1];
   logic [POS_W-1:0] prefix_ff [0:LEVELS-1];
   logic [POS_W-1:0] prefix_in [0:LEVELS-1];
   logic [POS_W-1:0] cons_ff   [0:LEVELS-1];
   logic [POS_W-1:0] cons_in   [0:LEVELS-1];
   logic [LEVELS-1:0] bank_ff, bank_in;

   state_type state_ff, state_in;
   logic [15:0] seg_ff, seg_in;

   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             zero_ff, zero_in;
   status_type       sts_ff, sts_in;
   logic             dup_ff, dup_in;
   logic             rdok_ff, rdok_in;
   logic [POS_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0] k_ff, k_in, w_ff, w_in;
   logic             placed_ff, placed_in;
   logic             absorbed_ff, absorbed_in;
   logic [29:0]      pend_ff, pend_in;
   logic [29:0]      first_ff, first_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [14:0]      rsp_prefix_ff, rsp_prefix_in;
   logic [14:0]      rsp_cons_ff, rsp_cons_in;
   logic [14:0]      rsp_avail_ff, rsp_avail_in;
   logic             rsp_dup_ff, rsp_dup_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic [4:0]       rsp_cnt_ff, rsp_cnt_in;

   // memory ports
   logic               byte_we, byte_re;
   logic [BYTE_AW-1:0] byte_waddr, byte_raddr;
   logic [7:0]         byte_wdata, byte_rdata_ff;
   logic               rng_we, rng_re;
   logic [RNG_AW-1:0]  rng_waddr, rng_raddr;
   logic [29:0]        rng_wdata, rng_rdata_ff;

   // request decode
   logic             accept;
   logic [LVL_W-1:0] in_lvl;
   logic             in_lvl_ok;
   logic [32:0]      in_end;
   logic             in_beyond;
   logic [POS_W-1:0] in_avail;
   logic [POS_W-1:0] cur_avail;

   // range walk decode
   logic [POS_W-1:0] r_s, r_e;
   logic             walk_full;
   logic [29:0]      fin_first;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign in_lvl    = LVL_W'(req_level);
   assign in_lvl_ok = ({30'd0, req_level} < LEVELS);
   assign in_end    = {1'b0, req_offset} + {17'd0, req_length};
   assign in_beyond = (in_end > 33'(BUFFER_BYTES));
   assign in_avail  = (prefix_ff[in_lvl] >= cons_ff[in_lvl]) ?
                      (prefix_ff[in_lvl] - cons_ff[in_lvl]) : '0;
   assign cur_avail = (prefix_ff[lvl_ff] >= cons_ff[lvl_ff]) ?
                      (prefix_ff[lvl_ff] - cons_ff[lvl_ff]) : '0;
   assign r_s       = POS_W'(rng_rdata_ff[29:15]);
   assign r_e       = POS_W'(rng_rdata_ff[14:0]);
   assign walk_full = !absorbed_ff && (cnt_ff[lvl_ff] >= CNT_W'(MAX_RANGES));
   assign fin_first = (w_ff == '0 && !placed_ff) ?
                      {15'(lo_ff), 15'(hi_ff)} : first_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!in_lvl_ok) begin
                  state_in = (req_type == REQ_SEGMENT && !req_last_byte) ? ST_IDLE : ST_DONE;
               end else if (req_type == REQ_SEGMENT) begin
                  if (!req_last_byte)
                     state_in = ST_IDLE;
                  else if (!in_beyond && req_length != 16'd0)
                     state_in = ST_RD;
                  else
                     state_in = ST_DONE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RD:    state_in = (k_ff < cnt_ff[lvl_ff]) ? ST_PROC : ST_END;
         ST_PROC: begin
            if (!placed_ff && r_e >= lo_ff && r_s > hi_ff)
               state_in = ST_EMIT2;
            else
               state_in = ST_RD;
         end
         ST_EMIT2: state_in = ST_RD;
         ST_END:   state_in = ST_DONE;
         ST_DONE:  state_in = (!rsp_valid_ff || rsp_ready) ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in      = cnt_ff;
      prefix_in   = prefix_ff;
      cons_in     = cons_ff;
      bank_in     = bank_ff;
      seg_in      = seg_ff;
      lvl_in      = lvl_ff;
      zero_in     = zero_ff;
      sts_in      = sts_ff;
      dup_in      = dup_ff;
      rdok_in     = rdok_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      k_in        = k_ff;
      w_in        = w_ff;
      placed_in   = placed_ff;
      absorbed_in = absorbed_ff;
      pend_in     = pend_ff;
      first_in    = first_ff;
      byte_we     = 1'b0;
      byte_waddr  = {in_lvl, BUF_AW'(req_offset) + BUF_AW'(seg_ff)};
      byte_wdata  = req_data_byte;
      byte_re     = 1'b0;
      byte_raddr  = {in_lvl, BUF_AW'(cons_ff[in_lvl]) + BUF_AW'(req_offset)};
      rng_re      = 1'b0;
      rng_raddr   = {bank_ff[lvl_ff], lvl_ff, RIDX_W'(k_ff)};
      rng_we      = 1'b0;
      rng_waddr   = {~bank_ff[lvl_ff], lvl_ff, RIDX_W'(w_ff)};
      rng_wdata   = rng_rdata_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_prefix_in = rsp_prefix_ff;
      rsp_cons_in   = rsp_cons_ff;
      rsp_avail_in  = rsp_avail_ff;
      rsp_dup_in    = rsp_dup_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lvl_in  = in_lvl;
               zero_in = !in_lvl_ok;
               sts_in  = STS_OK;
               dup_in  = 1'b0;
               rdok_in = 1'b0;
               if (in_lvl_ok) begin
                  seg_in = 16'd0;
                  case (req_type)
                     REQ_SEGMENT: begin
                        // write the byte while inside the segment and buffer
                        byte_we = !in_beyond && (seg_ff < req_length);
                        if (!req_last_byte) begin
                           seg_in = seg_ff + 16'd1;
                        end else if (in_beyond) begin
                           sts_in = STS_BEYOND;
                        end else begin
                           lo_in       = POS_W'(req_offset);
                           hi_in       = POS_W'(in_end);
                           k_in        = '0;
                           w_in        = '0;
                           placed_in   = 1'b0;
                           absorbed_in = 1'b0;
                        end
                     end
                     REQ_RELEASE: begin
                        if (req_length > 16'(in_avail))
                           sts_in = STS_RELEASE;
                        else
                           cons_in[in_lvl] = cons_ff[in_lvl] + POS_W'(req_length);
                     end
                     REQ_DUP: begin
                        dup_in = (req_length != 16'd0) &&
                                 (in_end <= 33'(prefix_ff[in_lvl]));
                     end
                     REQ_READ: begin
                        if (req_offset < 32'(in_avail)) begin
                           byte_re = 1'b1;
                           rdok_in = 1'b1;
                        end else begin
                           sts_in = STS_READ_RANGE;
                        end
                     end
                     REQ_CLEAR: begin
                        cnt_in[in_lvl]    = '0;
                        prefix_in[in_lvl] = '0;
                        cons_in[in_lvl]   = '0;
                     end
                     default: ;
                  endcase
               end
            end
         end
         // fetch the next stored range
         ST_RD: begin
            if (k_ff < cnt_ff[lvl_ff]) begin
               rng_re = 1'b1;
               k_in   = k_ff + 1'b1;
            end
         end
         // keep ranges before, absorb touching ones, emit new range before later ones
         ST_PROC: begin
            if (!placed_ff && r_e < lo_ff) begin
               rng_we = (w_ff < CNT_W'(MAX_RANGES));
               if (w_ff == '0) first_in = rng_rdata_ff;
               w_in = w_ff + 1'b1;
            end else if (!placed_ff && r_s <= hi_ff) begin
               absorbed_in = 1'b1;
               if (r_s < lo_ff) lo_in = r_s;
               if (r_e > hi_ff) hi_in = r_e;
            end else if (!placed_ff) begin
               rng_we    = (w_ff < CNT_W'(MAX_RANGES));
               rng_wdata = {15'(lo_ff), 15'(hi_ff)};
               if (w_ff == '0) first_in = {15'(lo_ff), 15'(hi_ff)};
               w_in      = w_ff + 1'b1;
               placed_in = 1'b1;
               pend_in   = rng_rdata_ff;
            end else begin
               rng_we = (w_ff < CNT_W'(MAX_RANGES));
               w_in   = w_ff + 1'b1;
            end
         end
         ST_EMIT2: begin
            rng_we    = (w_ff < CNT_W'(MAX_RANGES));
            rng_wdata = pend_ff;
            w_in      = w_ff + 1'b1;
         end
         // append the new range if still pending, then commit the list unless the range set is full
         ST_END: begin
            if (walk_full) begin
               sts_in = STS_FULL;
            end else begin
               if (!placed_ff) begin
                  rng_we    = (w_ff < CNT_W'(MAX_RANGES));
                  rng_wdata = {15'(lo_ff), 15'(hi_ff)};
               end
               cnt_in[lvl_ff]    = placed_ff ? w_ff : (w_ff + 1'b1);
               bank_in[lvl_ff]   = ~bank_ff[lvl_ff];
               prefix_in[lvl_ff] = (fin_first[29:15] == 15'd0) ?
                                   POS_W'(fin_first[14:0]) : '0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = zero_ff ? STS_OK : sts_ff;
               rsp_prefix_in = zero_ff ? 15'd0 : 15'(prefix_ff[lvl_ff]);
               rsp_cons_in   = zero_ff ? 15'd0 : 15'(cons_ff[lvl_ff]);
               rsp_avail_in  = zero_ff ? 15'd0 : 15'(cur_avail);
               rsp_dup_in    = zero_ff ? 1'b0 : dup_ff;
               rsp_byte_in   = (!zero_ff && rdok_ff) ? byte_rdata_ff : 8'd0;
               rsp_cnt_in    = zero_ff ? 5'd0 : 5'(cnt_ff[lvl_ff]);
            end
         end
         default: ;
      endcase
   end

   // byte store
   always_ff @(posedge clock) begin
      if (byte_we) byte_mem[byte_waddr] <= byte_wdata;
      if (byte_re) byte_rdata_ff <= byte_mem[byte_raddr];
   end

   // ping-pong range store
   always_ff @(posedge clock) begin
      if (rng_we) rng_mem[rng_waddr] <= rng_wdata;
      if (rng_re) rng_rdata_ff <= rng_mem[rng_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_ff       <= 16'd0;
         bank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            cnt_ff[i]    <= '0;
            prefix_ff[i] <= '0;
            cons_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         prefix_ff    <= prefix_in;
         cons_ff      <= cons_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      lvl_ff        <= lvl_in;
      zero_ff       <= zero_in;
      sts_ff        <= sts_in;
      dup_ff        <= dup_in;
      rdok_ff       <= rdok_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      k_ff          <= k_in;
      w_ff          <= w_in;
      placed_ff     <= placed_in;
      absorbed_ff   <= absorbed_in;
      pend_ff       <= pend_in;
      first_ff      <= first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_prefix_ff <= rsp_prefix_in;
      rsp_cons_ff   <= rsp_cons_in;
      rsp_avail_ff  <= rsp_avail_in;
      rsp_dup_ff    <= rsp_dup_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_prefix_len      = rsp_prefix_ff;
   assign rsp_consumed_count  = rsp_cons_ff;
   assign rsp_available       = rsp_avail_ff;
   assign rsp_is_duplicate    = rsp_dup_ff;
   assign rsp_read_byte       = rsp_byte_ff;
   assign rsp_range_count_out = rsp_cnt_ff;

endmodule
